### rtl/core/ccc_pkg.sv
// ----------------------------------------------------------------------------
// Cube coordinate codec package
// Command codes, micro-operations, the control store and the binomial table
// shared by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ccc_pkg;

	localparam int DigitsW = 24;
	localparam int CoordW  = 13;
	localparam int CmdW    = 3;
	localparam int ErrW    = 2;
	localparam int SlotW   = 4;
	localparam int PcW     = 3;
	localparam int LeftW   = 3;

	localparam logic [CmdW-1:0] CMD_PACK_CORNER   = 3'd0;
	localparam logic [CmdW-1:0] CMD_PACK_EDGE     = 3'd1;
	localparam logic [CmdW-1:0] CMD_RANK_SLICE    = 3'd2;
	localparam logic [CmdW-1:0] CMD_UNPACK_CORNER = 3'd3;
	localparam logic [CmdW-1:0] CMD_UNPACK_EDGE   = 3'd4;
	localparam logic [CmdW-1:0] CMD_UNRANK_SLICE  = 3'd5;

	localparam logic [ErrW-1:0] ERR_NONE      = 2'd0;
	localparam logic [ErrW-1:0] ERR_DIGIT     = 2'd1;
	localparam logic [ErrW-1:0] ERR_FEW_MARKS = 2'd2;
	localparam logic [ErrW-1:0] ERR_RANK      = 2'd3;

	localparam logic [CoordW-1:0] SLICE_MAX  = 13'd494;
	localparam logic [LeftW-1:0]  MARKS      = 3'd4;
	localparam logic [SlotW-1:0]  LAST_SLOT  = 4'd11;
	localparam logic [SlotW-1:0]  LAST_CORNER = 4'd7;
	localparam logic [11:0]       RECIP3     = 12'd2731;

	typedef enum logic [3:0] {
		OP_DONE,
		OP_PACK3,
		OP_PACK2,
		OP_RANK,
		OP_UNPACK3,
		OP_UNPACK2,
		OP_CHECK,
		OP_UNRANK
	} op_t;

	localparam logic [PcW-1:0] PC_DONE     = 3'd0;
	localparam logic [PcW-1:0] PC_PACK3    = 3'd1;
	localparam logic [PcW-1:0] PC_PACK2    = 3'd2;
	localparam logic [PcW-1:0] PC_RANK     = 3'd3;
	localparam logic [PcW-1:0] PC_UNPACK3  = 3'd4;
	localparam logic [PcW-1:0] PC_UNPACK2  = 3'd5;
	localparam logic [PcW-1:0] PC_CHECK    = 3'd6;
	localparam logic [PcW-1:0] PC_UNRANK   = 3'd7;

	// A step repeats until the slot counter reaches last, then jumps to next.
	typedef struct packed {
		op_t            op;
		logic [SlotW-1:0] last;
		logic [PcW-1:0]   next;
	} uword_t;

	typedef struct packed {
		logic             load;
		logic             run;
		op_t              op;
		logic [SlotW-1:0] slot;
	} dp_ctrl_t;

	function automatic uword_t ucode(input logic [PcW-1:0] pc);
		uword_t w;
		unique case (pc)
			PC_DONE:    w = '{OP_DONE,    4'd0,        PC_DONE};
			PC_PACK3:   w = '{OP_PACK3,   LAST_CORNER, PC_DONE};
			PC_PACK2:   w = '{OP_PACK2,   LAST_SLOT,   PC_DONE};
			PC_RANK:    w = '{OP_RANK,    LAST_SLOT,   PC_DONE};
			PC_UNPACK3: w = '{OP_UNPACK3, LAST_CORNER, PC_DONE};
			PC_UNPACK2: w = '{OP_UNPACK2, LAST_SLOT,   PC_DONE};
			PC_CHECK:   w = '{OP_CHECK,   4'd0,        PC_UNRANK};
			PC_UNRANK:  w = '{OP_UNRANK,  LAST_SLOT,   PC_DONE};
			default:    w = '{OP_DONE,    4'd0,        PC_DONE};
		endcase
		return w;
	endfunction

	function automatic logic [PcW-1:0] entry_pc(input logic [CmdW-1:0] cmd);
		logic [PcW-1:0] pc;
		unique case (cmd)
			CMD_PACK_CORNER:   pc = PC_PACK3;
			CMD_PACK_EDGE:     pc = PC_PACK2;
			CMD_RANK_SLICE:    pc = PC_RANK;
			CMD_UNPACK_CORNER: pc = PC_UNPACK3;
			CMD_UNPACK_EDGE:   pc = PC_UNPACK2;
			CMD_UNRANK_SLICE:  pc = PC_CHECK;
			default:           pc = PC_DONE;
		endcase
		return pc;
	endfunction

	// n choose k for n 0..11 and k 0..3, zero where n < k.
	localparam logic [7:0] BINOM [12][4] = '{
		'{8'd1, 8'd0,  8'd0,  8'd0},   '{8'd1, 8'd1,  8'd0,  8'd0},
		'{8'd1, 8'd2,  8'd1,  8'd0},   '{8'd1, 8'd3,  8'd3,  8'd1},
		'{8'd1, 8'd4,  8'd6,  8'd4},   '{8'd1, 8'd5,  8'd10, 8'd10},
		'{8'd1, 8'd6,  8'd15, 8'd20},  '{8'd1, 8'd7,  8'd21, 8'd35},
		'{8'd1, 8'd8,  8'd28, 8'd56},  '{8'd1, 8'd9,  8'd36, 8'd84},
		'{8'd1, 8'd10, 8'd45, 8'd120}, '{8'd1, 8'd11, 8'd55, 8'd165}
	};

	function automatic logic [7:0] binom(input logic [SlotW-1:0] n, input logic [1:0] k);
		logic [7:0] b;
		if (n > LAST_SLOT) begin
			b = 8'd0;
		end else begin
			b = BINOM[n][k];
		end
		return b;
	endfunction

endpackage

### rtl/core/ccc_datapath.sv
// ----------------------------------------------------------------------------
// Cube coordinate codec datapath
// Work registers and the per-slot operations driven by the control word.
// ----------------------------------------------------------------------------
module ccc_datapath (
	input  logic                           clk,
	input  ccc_pkg::dp_ctrl_t              ctrl,
	input  logic [ccc_pkg::CmdW-1:0]       cmd,
	input  logic [ccc_pkg::DigitsW-1:0]    digits,
	input  logic [ccc_pkg::CoordW-1:0]     coordinate,
	output logic [ccc_pkg::CoordW-1:0]     coord_out,
	output logic [ccc_pkg::DigitsW-1:0]    digits_out,
	output logic [ccc_pkg::ErrW-1:0]       error
);
	import ccc_pkg::*;

	logic [CmdW-1:0]    cmd_q;
	logic [DigitsW-1:0] digits_q;
	logic [CoordW-1:0]  work_q;
	logic [CoordW-1:0]  weight_q;
	logic [DigitsW-1:0] res_q;
	logic [LeftW-1:0]   left_q;
	logic [ErrW-1:0]    err_q;

	logic [4:0]         bit_idx;
	logic [1:0]         dig;
	logic [CoordW-1:0]  weight_x2;
	logic [CoordW-1:0]  addend;
	logic [24:0]        prod3;
	logic [11:0]        quot3;
	logic [CoordW-1:0]  rem3;
	logic [7:0]         bcoef;
	logic [ErrW-1:0]    err_fin;
	logic               is_enc;
	logic               is_dec;

	assign bit_idx   = {ctrl.slot, 1'b0};
	assign dig       = digits_q[bit_idx +: 2];
	assign weight_x2 = {weight_q[CoordW-2:0], 1'b0};
	assign addend    = (dig == 2'd1) ? weight_q : ((dig == 2'd2) ? weight_x2 : '0);
	assign prod3     = work_q * RECIP3;
	assign quot3     = prod3[24:13];
	assign rem3      = work_q - ({1'b0, quot3} + {quot3, 1'b0});
	assign bcoef     = binom(LAST_SLOT - ctrl.slot, 2'(left_q - 3'd1));

	assign is_enc  = (cmd_q <= CMD_RANK_SLICE);
	assign is_dec  = (cmd_q >= CMD_UNPACK_CORNER) && (cmd_q <= CMD_UNRANK_SLICE);
	assign err_fin = ((cmd_q == CMD_RANK_SLICE) && (left_q != 3'd0)) ? ERR_FEW_MARKS : err_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q    <= cmd;
			digits_q <= digits;
			work_q   <= (cmd >= CMD_UNPACK_CORNER) ? coordinate : '0;
			weight_q <= 13'd1;
			res_q    <= '0;
			left_q   <= MARKS;
			err_q    <= ERR_NONE;
		end else if (ctrl.run) begin
			case (ctrl.op)
				OP_PACK3: begin
					if (dig == 2'd3) begin
						err_q <= ERR_DIGIT;
					end
					work_q   <= work_q + addend;
					weight_q <= weight_q + weight_x2;
				end
				OP_PACK2: begin
					if (dig[1]) begin
						err_q <= ERR_DIGIT;
					end
					work_q   <= work_q + addend;
					weight_q <= weight_x2;
				end
				OP_RANK: begin
					if (left_q != 3'd0) begin
						if (dig != 2'd0) begin
							left_q <= left_q - 3'd1;
						end else begin
							work_q <= work_q + {5'd0, bcoef};
						end
					end
				end
				OP_UNPACK3: begin
					res_q[bit_idx +: 2] <= rem3[1:0];
					work_q              <= {1'b0, quot3};
				end
				OP_UNPACK2: begin
					res_q[bit_idx +: 2] <= {1'b0, work_q[0]};
					work_q              <= {1'b0, work_q[CoordW-1:1]};
				end
				OP_CHECK: begin
					if (work_q > SLICE_MAX) begin
						err_q <= ERR_RANK;
					end
				end
				OP_UNRANK: begin
					if (left_q != 3'd0) begin
						if (work_q >= {5'd0, bcoef}) begin
							work_q <= work_q - {5'd0, bcoef};
						end else begin
							res_q[bit_idx +: 2] <= 2'd1;
							left_q              <= left_q - 3'd1;
						end
					end
				end
				OP_DONE: begin
					error      <= err_fin;
					coord_out  <= (is_enc && (err_fin == ERR_NONE)) ? work_q : '0;
					digits_out <= (is_dec && (err_fin == ERR_NONE)) ? res_q : '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/cube_coordinate_codec_top.sv
// ----------------------------------------------------------------------------
// Cube coordinate codec
// Packs and ranks cube coordinates and decodes them again, under control of
// a small microprogram that walks the slots one per cycle.
//
//   Channel   Ports                               Transfer
//   command   start, busy, cmd, digits, coordinate start high while busy low
//   result    done, coord_out, digits_out, error  done high for one cycle
//
// A command steps one slot per cycle through the datapath: 8 steps for
// corners, 12 for edges and slice rank, 13 for slice unrank (range check
// plus 12 slots), 0 for an unknown command, plus one step that writes the
// result. The result appears in the same cycle that busy falls, and the next
// command can be taken in that cycle too. Reset clears the sequencer; the
// result ports hold no defined value until the first done. The receiver
// cannot stall the block.
// ----------------------------------------------------------------------------
module cube_coordinate_codec_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ccc_pkg::CmdW-1:0]       cmd,
	input  logic [ccc_pkg::DigitsW-1:0]    digits,
	input  logic [ccc_pkg::CoordW-1:0]     coordinate,
	output logic                           done,
	output logic [ccc_pkg::CoordW-1:0]     coord_out,
	output logic [ccc_pkg::DigitsW-1:0]    digits_out,
	output logic [ccc_pkg::ErrW-1:0]       error
);
	import ccc_pkg::*;

	logic             run_q, run_d;
	logic             done_q, done_d;
	logic [PcW-1:0]   pc_q, pc_d;
	logic [SlotW-1:0] slot_q, slot_d;
	logic             accept;
	uword_t           uw;
	dp_ctrl_t         ctrl;

	assign accept = start && !run_q;
	assign uw     = ucode(pc_q);
	assign busy   = run_q;
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			pc_q   <= PC_DONE;
			slot_q <= '0;
		end else begin
			run_q  <= run_d;
			done_q <= done_d;
			pc_q   <= pc_d;
			slot_q <= slot_d;
		end
	end

	always_comb begin
		run_d  = run_q;
		done_d = 1'b0;
		pc_d   = pc_q;
		slot_d = slot_q;
		if (accept) begin
			run_d  = 1'b1;
			pc_d   = entry_pc(cmd);
			slot_d = '0;
		end else if (run_q) begin
			if (uw.op == OP_DONE) begin
				run_d  = 1'b0;
				done_d = 1'b1;
			end
			if (slot_q == uw.last) begin
				slot_d = '0;
				pc_d   = uw.next;
			end else begin
				slot_d = slot_q + 4'd1;
			end
		end
	end

	always_comb begin
		ctrl.load = accept;
		ctrl.run  = run_q;
		ctrl.op   = uw.op;
		ctrl.slot = slot_q;
	end

	ccc_datapath u_dpath (
		.clk        (clk),
		.ctrl       (ctrl),
		.cmd        (cmd),
		.digits     (digits),
		.coordinate (coordinate),
		.coord_out  (coord_out),
		.digits_out (digits_out),
		.error      (error)
	);

endmodule

### rtl/core/ccc_checker.sv
// ----------------------------------------------------------------------------
// Cube coordinate codec checker
// Port-level checks of handshake timing and rank error fields, bound to top.
// ----------------------------------------------------------------------------
module ccc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [ccc_pkg::CoordW-1:0]     coord_out,
	input logic [ccc_pkg::DigitsW-1:0]    digits_out,
	input logic [ccc_pkg::ErrW-1:0]       error
);
	import ccc_pkg::*;

	a_take_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe not preceded by a busy command");

	a_rank_error_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && (error == ERR_RANK) |-> (coord_out == '0) && (digits_out == '0))
		else $error("rank range error with nonzero result fields");

endmodule

bind cube_coordinate_codec_top ccc_checker u_ccc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.coord_out  (coord_out),
	.digits_out (digits_out),
	.error      (error)
);
